/* rtl/core/sbce_pkg.sv */
// Shared types, constants and tables of the servo bus command encoder.
`default_nettype none
package sbce_pkg;

    // Widths of the work registers
    localparam int REM_W   = 19;   // holds |angle| * 1000 up to 270000
    localparam int MAG_W   = 9;    // span magnitude 180 or 270
    localparam int WGT_W   = 10;   // decimal weights up to 1000
    localparam int QUO_W   = 10;   // quotient up to 1000
    localparam int PULSE_W = 12;   // pulse up to 2500 before clamp
    localparam int IDX_W   = 5;    // byte index 0..16

    // Command kinds
    localparam logic OP_MODE  = 1'b0;
    localparam logic OP_ANGLE = 1'b1;

    // Pulse mapping constants
    localparam logic [REM_W-1:0]   ANGLE_SCALE = 19'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MID   = 12'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MIN   = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd2500;
    localparam logic [MAG_W-1:0]   MAG_270     = 9'd270;
    localparam logic [MAG_W-1:0]   MAG_180     = 9'd180;

    // Span codes: -270, +270, -180, +180
    localparam logic [1:0] SPAN_N270 = 2'd0;
    localparam logic [1:0] SPAN_P270 = 2'd1;
    localparam logic [1:0] SPAN_N180 = 2'd2;
    localparam logic [1:0] SPAN_P180 = 2'd3;

    // Last byte index of each command
    localparam logic [IDX_W-1:0] MODE_LAST_IDX  = 5'd11;
    localparam logic [IDX_W-1:0] ANGLE_LAST_IDX = 5'd16;

    // ASCII characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result of the shared compare-subtract unit
    typedef struct packed {
        logic             ge;     // remainder >= operand
        logic [REM_W-1:0] diff;   // remainder - operand
    } sbce_sub_t;

    // Everything the byte formatter needs for one command
    typedef struct packed {
        logic             op;
        logic [7:0]       mode;
        logic [11:0]      addr_dig;   // hundreds, tens, ones nibbles
        logic [15:0]      pulse_dig;  // thousands .. ones nibbles
    } sbce_fmt_t;

    // Span magnitude for a span code
    function automatic logic [MAG_W-1:0] span_mag(input logic [1:0] code);
        logic [MAG_W-1:0] m;
        case (code)
            SPAN_N270, SPAN_P270: m = MAG_270;
            default:              m = MAG_180;
        endcase
        return m;
    endfunction

    // Negative spans clamp symmetric, positive ones from zero
    function automatic logic span_is_neg(input logic [1:0] code);
        return (code == SPAN_N270) || (code == SPAN_N180);
    endfunction

    // Decimal weight by digit position: 1000, 100, 10, 1
    function automatic logic [WGT_W-1:0] dec_weight(input logic [1:0] pos);
        logic [WGT_W-1:0] w;
        case (pos)
            2'd0:    w = 10'd1000;
            2'd1:    w = 10'd100;
            2'd2:    w = 10'd10;
            default: w = 10'd1;
        endcase
        return w;
    endfunction

    // ASCII byte of one decimal digit
    function automatic logic [7:0] dec_char(input logic [3:0] nib);
        return CH_ZERO | {4'h0, nib};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/servo_bus_command_encoder.sv */
// Top level: sequencer of the serial bus servo command encoder.
`default_nettype none
// Takes one command item at a time and streams its ASCII command out byte by
// byte, LF flagged by m_tlast. A mode item takes the address conversion
// plus 12 byte beats; an angle item takes the address conversion, the clamp,
// the scaling, the division and the pulse conversion plus 17 byte beats, and
// the beats wait while m_tready stalls. The work runs on the single shared
// compare-subtract unit: one step per cycle for the three address digits
// (4 steps each), the restoring division by the span magnitude (10 steps)
// and the four pulse digits (4 steps each). s_tready is high only while no
// command is in progress. The servo address register may be written at any
// time through cfg_*; it is sampled when an item is accepted, so an item
// taken at the same edge as a write still uses the old address.
module servo_bus_command_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: servo address
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // Command items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] mode_char, [23:8] set_angle
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    // Command bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] command_byte
    output logic             m_tlast    // last_byte
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDR  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PULSE = 3'd5;
    localparam logic [2:0] S_PDIG  = 3'd6;
    localparam logic [2:0] S_SEND  = 3'd7;

    localparam logic [3:0] ADDR_LAST_STEP = 4'd11;
    localparam logic [3:0] DIV_LAST_STEP  = 4'd9;
    localparam logic [3:0] PDIG_LAST_STEP = 4'd15;

    logic [2:0]                      state_reg, state_next;
    logic [3:0]                      step_reg, step_next;
    logic [sbce_pkg::IDX_W-1:0]      byte_idx_reg, byte_idx_next;
    logic [1:0]                      span_reg, span_next;
    logic [7:0]                      addr_reg;
    logic                            op_reg, op_next;
    logic [7:0]                      mode_reg, mode_next;
    logic [15:0]                     angle_reg, angle_next;
    logic [sbce_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [sbce_pkg::MAG_W-1:0]      abs_reg, abs_next;
    logic                            neg_reg, neg_next;
    logic [sbce_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [11:0]                     addr_dig_reg, addr_dig_next;
    logic [15:0]                     pulse_dig_reg, pulse_dig_next;

    logic [sbce_pkg::REM_W-1:0]      operand;
    sbce_pkg::sbce_sub_t             sub_res;
    sbce_pkg::sbce_fmt_t             fmt;
    logic                            cmd_last;
    logic [sbce_pkg::MAG_W-1:0]      mag;
    logic [1:0]                      wgt_pos;
    logic signed [16:0]              ang_ext, lim_hi, lim_lo, ang_clamped, ang_abs;
    logic [sbce_pkg::PULSE_W-1:0]    pulse_raw, pulse_clamped;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_SEND);
    assign m_tlast   = cmd_last;
    assign mag       = sbce_pkg::span_mag(span_reg);

    // Operand of the shared unit: shifted decimal weight or shifted divisor
    always_comb begin
        if (state_reg == S_ADDR) begin
            wgt_pos = step_reg[3:2] + 2'd1;
        end else begin
            wgt_pos = step_reg[3:2];
        end
        if (state_reg == S_DIV) begin
            operand = {{(sbce_pkg::REM_W-sbce_pkg::MAG_W){1'b0}}, mag}
                      << (4'd9 - step_reg);
        end else begin
            operand = {{(sbce_pkg::REM_W-sbce_pkg::WGT_W){1'b0}},
                       sbce_pkg::dec_weight(wgt_pos)} << (2'd3 - step_reg[1:0]);
        end
    end

    sbce_sub_unit u_sub (
        .rem     (rem_reg),
        .operand (operand),
        .res     (sub_res)
    );

    // Clamp the angle to the current span
    always_comb begin
        ang_ext = {angle_reg[15], angle_reg};
        lim_hi  = {8'b0, mag};
        lim_lo  = sbce_pkg::span_is_neg(span_reg) ? -lim_hi : 17'sd0;
        if (ang_ext < lim_lo) begin
            ang_clamped = lim_lo;
        end else if (ang_ext > lim_hi) begin
            ang_clamped = lim_hi;
        end else begin
            ang_clamped = ang_ext;
        end
        ang_abs = ang_clamped[16] ? -ang_clamped : ang_clamped;
    end

    // Pulse around the midpoint, then clamp
    always_comb begin
        if (neg_reg) begin
            pulse_raw = sbce_pkg::PULSE_MID - {2'b0, quo_reg};
        end else begin
            pulse_raw = sbce_pkg::PULSE_MID + {2'b0, quo_reg};
        end
        if (pulse_raw < sbce_pkg::PULSE_MIN) begin
            pulse_clamped = sbce_pkg::PULSE_MIN;
        end else if (pulse_raw > sbce_pkg::PULSE_MAX) begin
            pulse_clamped = sbce_pkg::PULSE_MAX;
        end else begin
            pulse_clamped = pulse_raw;
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        byte_idx_next  = byte_idx_reg;
        span_next      = span_reg;
        op_next        = op_reg;
        mode_next      = mode_reg;
        angle_next     = angle_reg;
        rem_next       = rem_reg;
        abs_next       = abs_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        addr_dig_next  = addr_dig_reg;
        pulse_dig_next = pulse_dig_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    mode_next  = s_tdata[7:0];
                    angle_next = s_tdata[23:8];
                    rem_next   = {{(sbce_pkg::REM_W-8){1'b0}}, addr_reg};
                    step_next  = 4'd0;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                rem_next      = sub_res.ge ? sub_res.diff : rem_reg;
                addr_dig_next = {addr_dig_reg[10:0], sub_res.ge};
                step_next     = step_reg + 4'd1;
                if (step_reg == ADDR_LAST_STEP) begin
                    step_next     = 4'd0;
                    byte_idx_next = '0;
                    state_next    = (op_reg == sbce_pkg::OP_ANGLE) ? S_PREP : S_SEND;
                end
            end
            S_PREP: begin
                abs_next   = ang_abs[sbce_pkg::MAG_W-1:0];
                neg_next   = ang_clamped[16];
                state_next = S_MUL;
            end
            S_MUL: begin
                rem_next   = sbce_pkg::REM_W'(
                    {{(sbce_pkg::REM_W-sbce_pkg::MAG_W){1'b0}}, abs_reg}
                    * sbce_pkg::ANGLE_SCALE);
                step_next  = 4'd0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = sub_res.ge ? sub_res.diff : rem_reg;
                quo_next  = {quo_reg[sbce_pkg::QUO_W-2:0], sub_res.ge};
                step_next = step_reg + 4'd1;
                if (step_reg == DIV_LAST_STEP) begin
                    state_next = S_PULSE;
                end
            end
            S_PULSE: begin
                rem_next   = {{(sbce_pkg::REM_W-sbce_pkg::PULSE_W){1'b0}}, pulse_clamped};
                step_next  = 4'd0;
                state_next = S_PDIG;
            end
            S_PDIG: begin
                rem_next       = sub_res.ge ? sub_res.diff : rem_reg;
                pulse_dig_next = {pulse_dig_reg[14:0], sub_res.ge};
                step_next      = step_reg + 4'd1;
                if (step_reg == PDIG_LAST_STEP) begin
                    step_next     = 4'd0;
                    byte_idx_next = '0;
                    state_next    = S_SEND;
                end
            end
            S_SEND: begin
                if (m_tready) begin
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (cmd_last) begin
                        state_next = S_IDLE;
                        // mode '1'..'4' picks the new span after the command
                        if ((op_reg == sbce_pkg::OP_MODE) &&
                            (mode_reg inside {[sbce_pkg::CH_ONE:sbce_pkg::CH_FOUR]})) begin
                            span_next = mode_reg[1:0] - 2'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= 4'd0;
            byte_idx_reg <= '0;
            span_reg     <= sbce_pkg::SPAN_P180;
            addr_reg     <= 8'd0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            byte_idx_reg <= byte_idx_next;
            span_reg     <= span_next;
            if (cfg_valid) begin
                addr_reg <= cfg_data;
            end
        end
    end

    // Work registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        mode_reg      <= mode_next;
        angle_reg     <= angle_next;
        rem_reg       <= rem_next;
        abs_reg       <= abs_next;
        neg_reg       <= neg_next;
        quo_reg       <= quo_next;
        addr_dig_reg  <= addr_dig_next;
        pulse_dig_reg <= pulse_dig_next;
    end

    assign fmt.op        = op_reg;
    assign fmt.mode      = mode_reg;
    assign fmt.addr_dig  = addr_dig_reg;
    assign fmt.pulse_dig = pulse_dig_reg;

    sbce_byte_fmt u_fmt (
        .fmt      (fmt),
        .byte_idx (byte_idx_reg),
        .cmd_byte (m_tdata),
        .cmd_last (cmd_last)
    );

    // Input and output never open at the same time
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while bytes are being sent");

    // After the LF is taken the block takes the next item
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after last byte");

    // An accepted item starts work at once
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("accepted item did not start work");

    // Pulse digits stay decimal
    a_pulse_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (op_reg == sbce_pkg::OP_ANGLE)) |->
        ((pulse_dig_reg[15:12] <= 4'd9) && (pulse_dig_reg[11:8] <= 4'd9) &&
         (pulse_dig_reg[7:4] <= 4'd9) && (pulse_dig_reg[3:0] <= 4'd9)))
        else $error("pulse digit out of range");

endmodule
`default_nettype wire

/* rtl/core/sbce_sub_unit.sv */
// Shared compare-subtract unit used for division and decimal conversion.
`default_nettype none
module sbce_sub_unit (
    input  wire logic [sbce_pkg::REM_W-1:0] rem,
    input  wire logic [sbce_pkg::REM_W-1:0] operand,
    output sbce_pkg::sbce_sub_t             res
);

    logic [sbce_pkg::REM_W:0] wide_diff;

    // One subtraction; the borrow tells whether the operand fits
    always_comb begin
        wide_diff = {1'b0, rem} - {1'b0, operand};
        res.ge    = ~wide_diff[sbce_pkg::REM_W];
        res.diff  = wide_diff[sbce_pkg::REM_W-1:0];
    end

endmodule
`default_nettype wire

/* rtl/core/sbce_byte_fmt.sv */
// Byte formatter: picks the ASCII byte of a command by its position.
`default_nettype none
module sbce_byte_fmt (
    input  wire sbce_pkg::sbce_fmt_t          fmt,
    input  wire logic [sbce_pkg::IDX_W-1:0]   byte_idx,
    output logic [7:0]                        cmd_byte,
    output logic                              cmd_last
);

    logic [7:0] mode_byte;
    logic [7:0] angle_byte;

    // Bytes of "#aaaPMODm!" CR LF
    always_comb begin
        case (byte_idx)
            5'd0:    mode_byte = sbce_pkg::CH_HASH;
            5'd1:    mode_byte = sbce_pkg::dec_char(fmt.addr_dig[11:8]);
            5'd2:    mode_byte = sbce_pkg::dec_char(fmt.addr_dig[7:4]);
            5'd3:    mode_byte = sbce_pkg::dec_char(fmt.addr_dig[3:0]);
            5'd4:    mode_byte = sbce_pkg::CH_P;
            5'd5:    mode_byte = sbce_pkg::CH_M;
            5'd6:    mode_byte = sbce_pkg::CH_O;
            5'd7:    mode_byte = sbce_pkg::CH_D;
            5'd8:    mode_byte = fmt.mode;
            5'd9:    mode_byte = sbce_pkg::CH_BANG;
            5'd10:   mode_byte = sbce_pkg::CH_CR;
            default: mode_byte = sbce_pkg::CH_LF;
        endcase
    end

    // Bytes of "#aaaPppppT0100!" CR LF
    always_comb begin
        case (byte_idx)
            5'd0:    angle_byte = sbce_pkg::CH_HASH;
            5'd1:    angle_byte = sbce_pkg::dec_char(fmt.addr_dig[11:8]);
            5'd2:    angle_byte = sbce_pkg::dec_char(fmt.addr_dig[7:4]);
            5'd3:    angle_byte = sbce_pkg::dec_char(fmt.addr_dig[3:0]);
            5'd4:    angle_byte = sbce_pkg::CH_P;
            5'd5:    angle_byte = sbce_pkg::dec_char(fmt.pulse_dig[15:12]);
            5'd6:    angle_byte = sbce_pkg::dec_char(fmt.pulse_dig[11:8]);
            5'd7:    angle_byte = sbce_pkg::dec_char(fmt.pulse_dig[7:4]);
            5'd8:    angle_byte = sbce_pkg::dec_char(fmt.pulse_dig[3:0]);
            5'd9:    angle_byte = sbce_pkg::CH_T;
            5'd10:   angle_byte = sbce_pkg::CH_ZERO;
            5'd11:   angle_byte = sbce_pkg::CH_ONE;
            5'd12:   angle_byte = sbce_pkg::CH_ZERO;
            5'd13:   angle_byte = sbce_pkg::CH_ZERO;
            5'd14:   angle_byte = sbce_pkg::CH_BANG;
            5'd15:   angle_byte = sbce_pkg::CH_CR;
            default: angle_byte = sbce_pkg::CH_LF;
        endcase
    end

    // Select by command kind, flag the LF
    always_comb begin
        if (fmt.op == sbce_pkg::OP_ANGLE) begin
            cmd_byte = angle_byte;
            cmd_last = (byte_idx == sbce_pkg::ANGLE_LAST_IDX);
        end else begin
            cmd_byte = mode_byte;
            cmd_last = (byte_idx == sbce_pkg::MODE_LAST_IDX);
        end
    end

endmodule
`default_nettype wire
